### sv/dfr_pkg.sv
`timescale 1ns / 1ps
// Package for the DES round block: field widths and the standard DES tables
// (expansion E, permutation P, S-boxes S1..S8). No dependencies.
package dfr_pkg;

    localparam int HALF_W = 32;
    localparam int KEY_W  = 48;
    localparam int NUM_SBOX = 8;

    typedef logic [HALF_W-1:0] half_t;
    typedef logic [KEY_W-1:0]  key_t;

    // DES notation: entry n names bit n counted from the most significant bit, from 1
    localparam logic [5:0] EXP_TAB [0:47] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] PERM_TAB [0:31] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    // indexed by {row, col}: row is the outer two bits, col the inner four
    localparam logic [3:0] SBOX_TAB [0:7][0:63] = '{
        '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
          4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
          4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
          4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
        '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
          4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
          4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
          4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
        '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
          4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
          4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
          4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
        '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
          4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
          4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
          4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
        '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
          4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
          4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
          4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
        '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
          4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
          4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
          4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
        '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
          4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
          4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
          4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
        '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
          4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
          4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
          4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
    };

endpackage

### sv/dfr_in_if.sv
`timescale 1ns / 1ps
// Input channel of the DES round block: valid/ready plus the two halves and subkey.
// Depends on dfr_pkg.
interface dfr_in_if
    import dfr_pkg::*;
();
    logic  valid;
    logic  ready;
    half_t left_half;
    half_t right_half;
    key_t  round_subkey;

    modport source (output valid, output left_half, output right_half,
                    output round_subkey, input ready);
    modport sink   (input valid, input left_half, input right_half,
                    input round_subkey, output ready);
endinterface

### sv/dfr_out_if.sv
`timescale 1ns / 1ps
// Result channel of the DES round block: valid/ready plus the swapped halves.
// Depends on dfr_pkg.
interface dfr_out_if
    import dfr_pkg::*;
();
    logic  valid;
    logic  ready;
    half_t next_left;
    half_t next_right;

    modport source (output valid, output next_left, output next_right, input ready);
    modport sink   (input valid, input next_left, input next_right, output ready);
endinterface

### sv/dfr_f.sv
`timescale 1ns / 1ps
// DES round function f: expansion, key mix, S-boxes and P permutation.
// Pure combinational; depends on the tables in dfr_pkg.
module dfr_f
    import dfr_pkg::*;
(
    input  half_t right_half,
    input  key_t  round_subkey,
    output half_t f_out
);

    key_t  expanded;
    key_t  mixed;
    half_t sbox_out;

    always_comb
    begin
        for (int i = 0; i < KEY_W; i++)
        begin
            expanded[KEY_W-1-i] = right_half[5'(6'd32 - EXP_TAB[i])];
        end
    end

    assign mixed = expanded ^ round_subkey;

    always_comb
    begin
        logic [5:0] grp;
        grp = '0;
        for (int k = 0; k < NUM_SBOX; k++)
        begin
            grp = mixed[KEY_W-6-6*k +: 6];
            sbox_out[HALF_W-4-4*k +: 4] = SBOX_TAB[k][{grp[5], grp[0], grp[4:1]}];
        end
    end

    always_comb
    begin
        for (int i = 0; i < HALF_W; i++)
        begin
            f_out[HALF_W-1-i] = sbox_out[5'(6'd32 - PERM_TAB[i])];
        end
    end

endmodule

### sv/des_feistel_round.sv
`timescale 1ns / 1ps
// Top level of the DES Feistel round: input register, f logic, result register.
// Depends on dfr_pkg, dfr_in_if, dfr_out_if and dfr_f.
//
// Usage:
//   in_ch carries left_half, right_half and round_subkey; out_ch returns
//   next_left (= right_half) and next_right (= left_half ^ f). Both are
//   valid/ready channels; a transfer happens at a clock edge with both high.
//   Path: an item passes through the input register and then the result
//   register, and is presented on out_ch from the result register.
//   Throughput: one item per cycle while out_ch.ready stays high; the f
//   logic between the two registers (E, key XOR, S-box lookup, P) is the
//   only work.
//   Stall: while out_ch.ready is low a full result register holds; the input
//   register still takes one more item if it is empty, then in_ch.ready
//   drops until the result transfers.
//   Reset: rst_n (asynchronous, active low) empties both registers; no
//   result is pending afterwards. The block keeps no state between items.
module des_feistel_round
    import dfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dfr_in_if.sink    in_ch,
    dfr_out_if.source out_ch
);

    logic  in_valid_reg;
    logic  in_valid_next;
    half_t left_reg;
    half_t right_reg;
    key_t  key_reg;
    logic  out_valid_reg;
    logic  out_valid_next;
    half_t next_left_reg;
    half_t next_right_reg;
    half_t f_val;
    logic  advance;
    logic  in_take;

    dfr_f u_f (
        .right_half   (right_reg),
        .round_subkey (key_reg),
        .f_out        (f_val)
    );

    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_valid_next  = in_ch.ready ? in_ch.valid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            left_reg  <= in_ch.left_half;
            right_reg <= in_ch.right_half;
            key_reg   <= in_ch.round_subkey;
        end
        if (advance && in_valid_reg)
        begin
            next_left_reg  <= right_reg;
            next_right_reg <= left_reg ^ f_val;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.next_left  = next_left_reg;
    assign out_ch.next_right = next_right_reg;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench for des_feistel_round: drives random and corner-case DES rounds and checks
// each transfer on the result channel against a local model of the round.
// Depends on dfr_pkg, dfr_in_if, dfr_out_if and des_feistel_round.
module tb;
    import dfr_pkg::*;

    typedef struct packed {
        half_t left;
        half_t right;
        key_t  key;
    } round_in_t;

    typedef struct packed {
        half_t next_left;
        half_t next_right;
    } round_out_t;

    logic clk = 1'b0;
    logic rst_n;

    dfr_in_if  in_ch ();
    dfr_out_if out_ch ();

    des_feistel_round i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    round_in_t  pending_rounds [$];
    round_out_t expected_rounds [$];
    round_in_t  next_round;
    round_out_t want;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  send_hold = 1'b0;
    bit  recv_hold = 1'b0;
    bit  stall_go = 1'b0;
    bit  in_taken = 1'b0;
    int  rounds_sent = 0;
    int  results_checked = 0;
    int  err_cnt = 0;

    always #1 clk = ~clk;

    function automatic round_out_t feistel_round(round_in_t item);
        logic [47:0] mixed;
        logic [31:0] sbox_out;
        logic [31:0] f_val;
        logic [5:0]  grp;
        round_out_t  res;
        int          i;
        for (i = 0; i < 48; i++)
            mixed[47-i] = item.right[32-EXP_TAB[i]];
        mixed = mixed ^ item.key;
        for (i = 0; i < NUM_SBOX; i++)
        begin
            grp = mixed[47-6*i -: 6];
            sbox_out[31-4*i -: 4] = SBOX_TAB[i][{grp[5], grp[0], grp[4:1]}];
        end
        for (i = 0; i < 32; i++)
            f_val[31-i] = sbox_out[32-PERM_TAB[i]];
        res.next_left  = item.right;
        res.next_right = item.left ^ f_val;
        return res;
    endfunction

    task automatic add_round(half_t l, half_t r, key_t k);
        round_in_t item;
        item.left  = l;
        item.right = r;
        item.key   = k;
        pending_rounds.push_back(item);
    endtask

    task automatic add_random_rounds(int count);
        int n;
        for (n = 0; n < count; n++)
            add_round($urandom, $urandom, {16'($urandom), 32'($urandom)});
    endtask

    task automatic drain_pending();
        while (pending_rounds.size() != 0)
            @(posedge clk);
    endtask

    // sender: hold an offered transfer until taken, else maybe offer the next one
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_taken)
        begin
            if (!send_hold && pending_rounds.size() != 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                next_round = pending_rounds.pop_front();
                in_ch.left_half    <= next_round.left;
                in_ch.right_half   <= next_round.right;
                in_ch.round_subkey <= next_round.key;
                in_ch.valid        <= 1'b1;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        wait (stall_go);
        recv_hold = 1'b1;
        repeat (60) @(posedge clk);
        recv_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                expected_rounds.push_back(feistel_round(
                    {in_ch.left_half, in_ch.right_half, in_ch.round_subkey}));
                rounds_sent++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_rounds.size() == 0)
                begin
                    $error("unexpected result transfer: next_left=%h next_right=%h",
                           out_ch.next_left, out_ch.next_right);
                    err_cnt++;
                end
                else
                begin
                    want = expected_rounds.pop_front();
                    if (out_ch.next_left !== want.next_left)
                    begin
                        $error("next_left: expected %h, actual %h",
                               want.next_left, out_ch.next_left);
                        err_cnt++;
                    end
                    if (out_ch.next_right !== want.next_right)
                    begin
                        $error("next_right: expected %h, actual %h",
                               want.next_right, out_ch.next_right);
                        err_cnt++;
                    end
                    results_checked++;
                end
            end
        end
    end

    initial
    begin
        #200000;
        $display("tb failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.left_half    = '0;
        in_ch.right_half   = '0;
        in_ch.round_subkey = '0;
        out_ch.ready       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 64;
        add_round('0, '0, '0);
        add_round('1, '1, '1);
        add_round('0, '0, '1);
        add_round('1, '1, '0);
        add_round('1, '0, '0);
        add_round('0, '1, '1);
        // expansion wraps bit 32 to the front and bit 1 to the end
        add_round('0, 32'h0000_0001, '0);
        add_round('0, 32'h8000_0000, '0);
        add_round('0, 32'h8000_0001, 48'hFFFF_FFFF_FFFF);
        // S-box groups with only outer bits set, then only inner bits set
        add_round('0, '0, 48'h8618_6186_1861);
        add_round('0, '0, 48'h79E7_9E79_E79E);
        add_round(32'hAAAA_AAAA, 32'h5555_5555, 48'hAAAA_AAAA_AAAA);
        add_round(32'h5555_5555, 32'hAAAA_AAAA, 48'h5555_5555_5555);
        add_round(32'h0000_FFFF, 32'hFFFF_0000, 48'h0000_00FF_FFFF);
        add_round(32'hFFFF_0000, 32'h0000_FFFF, 48'hFFFF_FF00_0000);
        add_round(32'h0123_4567, 32'h89AB_CDEF, 48'h1B02_EFFC_7072);
        add_random_rounds(200);
        drain_pending();

        send_idle_pct = 64;
        recv_idle_pct = 33;
        add_random_rounds(200);
        drain_pending();

        // pause the sender until the block has returned everything
        send_hold = 1'b1;
        while (in_ch.valid || expected_rounds.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        send_hold = 1'b0;

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_rounds(225);
        @(posedge clk);
        stall_go = 1'b1;
        drain_pending();

        while (in_ch.valid || expected_rounds.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d rounds (corner halves, wrap bits, S-box rows/cols, random)",
                 rounds_sent);
        $display("checked %0d results under random stalls and a long output hold-off",
                 results_checked);
        if (err_cnt == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
